>>> sv/lacunary_cosine_series_macros.svh
// assertion macros used by the checker file of the lacunary cosine series block
`ifndef LACUNARY_COSINE_SERIES_MACROS_SVH
`define LACUNARY_COSINE_SERIES_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define LCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcs assertion failed");

// next-cycle implication, disabled while reset is active
`define LCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcs assertion failed");

`endif

>>> sv/lcs_pkg.sv
// shared types, constants and the quarter-wave sine function of the lacunary cosine series block
package lcs_pkg;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TH_W   = 30;
  localparam logic [0:0]  REG_STOP_THRESHOLD = 1'b0;
  localparam logic [TH_W-1:0] TH_RESET = 30'd1;

  // saturation bounds of the power register and the accumulator
  localparam logic signed [17:0] P_MAX   = 18'sh1ffff;
  localparam logic signed [17:0] P_MIN   = 18'sh20000;
  localparam logic signed [31:0] ACC_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] ACC_MIN = 32'sh80000000;

  // power register value of 1.0
  localparam logic signed [17:0] P_ONE = 18'sd32768;

  // quadrant codes of the table angle
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // odd polynomial coefficients for the quarter-wave sine, Q30
  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598668;
  localparam logic [63:0] POLY_C5 = 64'd85569306;
  localparam logic [63:0] POLY_C7 = 64'd5026995;
  localparam logic [63:0] POLY_C9 = 64'd172272;

  // one request to the shared two-product unit
  typedef struct packed {
    logic        en;
    logic        sub;
    logic [17:0] a;
    logic [17:0] b;
    logic [17:0] c;
    logic [17:0] d;
  } mac_op_t;

  // sin(pi/2 * t) for t in Q30 over [0, 1], rounded to Q1.15; used on constants only
  function automatic logic [15:0] quarter_sin(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] v;
    t2 = (t * t) >> 30;
    p  = POLY_C9;
    p  = POLY_C7 - ((p * t2) >> 30);
    p  = POLY_C5 - ((p * t2) >> 30);
    p  = POLY_C3 - ((p * t2) >> 30);
    p  = POLY_C1 - ((p * t2) >> 30);
    v  = (p * t) >> 30;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

endpackage

>>> sv/lcs_mac2.sv
// shared two-product unit: a*b plus or minus c*d, products registered, sum read in the cycle after the request
module lcs_mac2 (
  input  logic                clk_i,
  input  lcs_pkg::mac_op_t    op_i,
  output logic signed [36:0]  res_o
);

  logic signed [35:0] prod_ab_q;
  logic signed [35:0] prod_cd_q;
  logic               sub_q;

  // product stage, loaded only on a request
  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      prod_ab_q <= $signed(op_i.a) * $signed(op_i.b);
      prod_cd_q <= $signed(op_i.c) * $signed(op_i.d);
      sub_q     <= op_i.sub;
    end
  end

  // combine the two products
  assign res_o = sub_q ? (37'(prod_ab_q) - 37'(prod_cd_q))
                       : (37'(prod_ab_q) + 37'(prod_cd_q));

endmodule

>>> sv/lacunary_cosine_series.sv
// lacunary cosine series evaluator: sequencer, table, power and sum registers
// the result is loaded into the output register once the last term is checked, but is held back
// while a previous result still sits stalled in the output register
// a request is taken only in idle; the next is taken once the result is loaded
// each term makes four passes through the shared two-product unit and one update
// reset clears the sequencer and output valid, and sets stop_threshold to 1
// the cosine table is a constant quarter-wave array of 2^(COS_TABLE_BITS-2)+1 entries
module lacunary_cosine_series #(
  parameter int unsigned MAX_TERMS      = 64,
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // apb configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcs_pkg::ADDR_W-1:0]     paddr,
  input  logic [lcs_pkg::DATA_W-1:0]     pwdata,
  output logic [lcs_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             z_re_i,
  input  logic signed [15:0]             z_im_i,
  input  logic [15:0]                    ell_i,
  input  logic [31:0]                    phase_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             series_sum_o,
  output logic [6:0]                     terms_used_o,
  output logic                           not_converged_o
);

  localparam int unsigned QN        = 1 << (COS_TABLE_BITS - 2);
  localparam int unsigned TAB_AW    = COS_TABLE_BITS - 1;
  localparam int unsigned TAB_SHIFT = 32 - COS_TABLE_BITS;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_ANG0 = 10'b0000000010,
    ST_ANG1 = 10'b0000000100,
    ST_ANG2 = 10'b0000001000,
    ST_TERM = 10'b0000010000,
    ST_PRE  = 10'b0000100000,
    ST_PIM  = 10'b0001000000,
    ST_UPD  = 10'b0010000000,
    ST_MAG  = 10'b0100000000,
    ST_CHK  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [lcs_pkg::TH_W-1:0] th_q;
  logic signed [15:0]       z_re_q, z_im_q;
  logic [16:0]              mult_q;
  logic [31:0]              phase_q;
  logic [31:0]              angle_q;
  logic signed [17:0]       p_re_q, p_im_q, nr_q;
  logic signed [31:0]       acc_q;
  logic [6:0]               n_q;

  logic                     out_valid_q;
  logic signed [31:0]       sum_out_q;
  logic [6:0]               terms_out_q;
  logic                     flag_out_q;

  logic                     in_acc, out_free, cfg_wr;
  lcs_pkg::mac_op_t         mac_op;
  logic signed [36:0]       mac_res;

  // constant quarter-wave sine table
  logic [15:0] qtab [0:QN];
  for (genvar gi = 0; gi <= QN; gi++) begin : g_qtab
    assign qtab[gi] = lcs_pkg::quarter_sin(64'(gi) << TAB_SHIFT);
  end

  // table lookup from the current angle
  logic [COS_TABLE_BITS-1:0] tab_idx;
  logic [1:0]                quad;
  logic [TAB_AW-1:0]         k_sin, k_cos;
  logic [15:0]               sr, sc;
  logic signed [15:0]        cos_v, sin_v;

  assign tab_idx = angle_q[31 -: COS_TABLE_BITS];
  assign quad    = tab_idx[COS_TABLE_BITS-1 -: 2];
  assign k_sin   = {1'b0, tab_idx[COS_TABLE_BITS-3:0]};
  assign k_cos   = TAB_AW'(QN) - k_sin;
  assign sr      = qtab[k_sin];
  assign sc      = qtab[k_cos];

  always_comb begin
    case (quad)
      lcs_pkg::QUAD_0: begin
        sin_v = $signed(sr);
        cos_v = $signed(sc);
      end
      lcs_pkg::QUAD_1: begin
        sin_v = $signed(sc);
        cos_v = -$signed(sr);
      end
      lcs_pkg::QUAD_2: begin
        sin_v = -$signed(sr);
        cos_v = -$signed(sc);
      end
      default: begin
        sin_v = -$signed(sc);
        cos_v = $signed(sr);
      end
    endcase
  end

  // result post-processing: term rounding, power rounding, magnitude compare
  logic signed [36:0] term_w, p_rnd;
  logic signed [37:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic signed [17:0] p_sat;
  logic               mag_below, cap_hit, stop_w;

  assign term_w  = (mac_res + 37'sd32) >>> 6;
  assign acc_sum = 38'(acc_q) + 38'(term_w);
  assign acc_sat = (acc_sum > 38'(lcs_pkg::ACC_MAX)) ? lcs_pkg::ACC_MAX :
                   (acc_sum < 38'(lcs_pkg::ACC_MIN)) ? lcs_pkg::ACC_MIN : acc_sum[31:0];

  assign p_rnd = (mac_res + 37'sd16384) >>> 15;
  assign p_sat = (p_rnd > 37'(lcs_pkg::P_MAX)) ? lcs_pkg::P_MAX :
                 (p_rnd < 37'(lcs_pkg::P_MIN)) ? lcs_pkg::P_MIN : p_rnd[17:0];

  assign mag_below = mac_res < $signed({7'd0, th_q});
  assign cap_hit   = n_q >= 7'(MAX_TERMS);
  assign stop_w    = mag_below || cap_hit;

  // handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // operand selection for the shared unit
  always_comb begin
    mac_op = '0;
    case (state_q)
      ST_ANG0: begin
        mac_op.en = 1'b1;
        mac_op.a  = {2'b00, phase_q[15:0]};
        mac_op.b  = {1'b0, mult_q};
      end
      ST_ANG1: begin
        mac_op.en = 1'b1;
        mac_op.a  = {2'b00, phase_q[31:16]};
        mac_op.b  = {1'b0, mult_q};
      end
      ST_TERM, ST_CHK: begin
        mac_op.en  = (state_q == ST_TERM) || !stop_w;
        mac_op.sub = 1'b1;
        mac_op.a   = p_re_q;
        mac_op.b   = {{2{cos_v[15]}}, cos_v};
        mac_op.c   = p_im_q;
        mac_op.d   = {{2{sin_v[15]}}, sin_v};
      end
      ST_PRE: begin
        mac_op.en  = 1'b1;
        mac_op.sub = 1'b1;
        mac_op.a   = p_re_q;
        mac_op.b   = {{2{z_re_q[15]}}, z_re_q};
        mac_op.c   = p_im_q;
        mac_op.d   = {{2{z_im_q[15]}}, z_im_q};
      end
      ST_PIM: begin
        mac_op.en = 1'b1;
        mac_op.a  = p_re_q;
        mac_op.b  = {{2{z_im_q[15]}}, z_im_q};
        mac_op.c  = p_im_q;
        mac_op.d  = {{2{z_re_q[15]}}, z_re_q};
      end
      ST_MAG: begin
        mac_op.en = 1'b1;
        mac_op.a  = p_re_q;
        mac_op.b  = p_re_q;
        mac_op.c  = p_im_q;
        mac_op.d  = p_im_q;
      end
      default: begin
        mac_op = '0;
      end
    endcase
  end

  lcs_mac2 u_mac2 (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_ANG0;
      end
      ST_ANG0: state_d = ST_ANG1;
      ST_ANG1: state_d = ST_ANG2;
      ST_ANG2: state_d = ST_TERM;
      ST_TERM: state_d = ST_PRE;
      ST_PRE:  state_d = ST_PIM;
      ST_PIM:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_MAG;
      ST_MAG:  state_d = ST_CHK;
      ST_CHK: begin
        if (!stop_w) begin
          state_d = ST_PRE;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          z_re_q  <= z_re_i;
          z_im_q  <= z_im_i;
          mult_q  <= {ell_i, 1'b1};
          phase_q <= phase_i;
          p_re_q  <= lcs_pkg::P_ONE;
          p_im_q  <= '0;
          acc_q   <= '0;
          n_q     <= '0;
        end
      end
      ST_ANG1: angle_q <= mac_res[31:0];
      ST_ANG2: angle_q <= angle_q + {mac_res[15:0], 16'h0000};
      ST_PRE:  acc_q   <= acc_sat;
      ST_PIM:  nr_q    <= p_sat;
      ST_UPD: begin
        p_re_q  <= nr_q;
        p_im_q  <= p_sat;
        n_q     <= n_q + 7'd1;
        angle_q <= {angle_q[30:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_CHK) && stop_w && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_CHK) && stop_w && out_free) begin
      sum_out_q   <= acc_q;
      terms_out_q <= n_q;
      flag_out_q  <= !mag_below;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign series_sum_o    = sum_out_q;
  assign terms_used_o    = terms_out_q;
  assign not_converged_o = flag_out_q;

  // configuration register
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_q <= lcs_pkg::TH_RESET;
    end else if (cfg_wr && (paddr[2] == lcs_pkg::REG_STOP_THRESHOLD)) begin
      th_q <= pwdata[lcs_pkg::TH_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lcs_pkg::REG_STOP_THRESHOLD) ?
                  {2'b00, th_q} : '0;

endmodule

>>> sv/lcs_checker.sv
// port-level checker for the lacunary cosine series block, with its bind
`include "lacunary_cosine_series_macros.svh"

module lcs_checker #(
  parameter int unsigned MAX_TERMS = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input logic signed [31:0] series_sum_i,
  input logic [6:0]         terms_used_i,
  input logic               not_converged_i
);

  // a held result keeps its payload
  `LCS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(series_sum_i) && $stable(terms_used_i) && $stable(not_converged_i))

  // one request at a time: an accepted request closes the input
  `LCS_ASSERT_NXT(a_in_busy, clk_i, rst_ni, in_valid_i && !in_stall_i, in_stall_i)

  // term count stays within the cap
  `LCS_ASSERT_IMP(a_terms_range, clk_i, rst_ni, out_valid_i, (terms_used_i >= 7'd1) && (terms_used_i <= 7'(MAX_TERMS)))

  // non-convergence only at the cap
  `LCS_ASSERT_IMP(a_flag_cap, clk_i, rst_ni, out_valid_i && not_converged_i, terms_used_i == 7'(MAX_TERMS))

endmodule

bind lacunary_cosine_series lcs_checker #(
  .MAX_TERMS (MAX_TERMS)
) u_lcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .series_sum_i    (series_sum_o),
  .terms_used_i    (terms_used_o),
  .not_converged_i (not_converged_o)
);

>>> test/lcs_series_checker.sv
// checker for the lacunary cosine series block: tracks the threshold, predicts and compares results
module lcs_series_checker #(
  parameter int unsigned TERM_CAP   = 64,
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcs_pkg::ADDR_W-1:0] paddr,
  input  logic [lcs_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic signed [15:0]         z_re_i,
  input  logic signed [15:0]         z_im_i,
  input  logic [15:0]                ell_i,
  input  logic [31:0]                phase_i,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic signed [31:0]         series_sum_o,
  input  logic [6:0]                 terms_used_o,
  input  logic                       not_converged_o,
  output int                         fail_count_o,
  output int                         pending_o
);
  import lcs_pkg::*;

  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = {REG_STOP_THRESHOLD, 2'b00};

  typedef struct packed {
    logic signed [31:0] sum;
    logic [6:0]         terms;
    logic               capped;
  } series_outcome_t;

  series_outcome_t expected_sums [$];
  logic [TH_W-1:0] threshold_q;
  int mismatches = 0;

  // sin(pi/2 * t) for t in q30 over a quarter wave, rounded to q1.15
  function automatic int quarter_wave_q15(input logic [63:0] t);
    logic [63:0] t_sq;
    logic [63:0] horner;
    logic [63:0] coef;
    logic [63:0] v;
    int k;
    t_sq   = (t * t) >> 30;
    horner = POLY_C9;
    for (k = 0; k < 4; k++) begin
      case (k)
        0: coef = POLY_C7;
        1: coef = POLY_C5;
        2: coef = POLY_C3;
        default: coef = POLY_C1;
      endcase
      horner = coef - ((horner * t_sq) >> 30);
    end
    v = (horner * t) >> 30;
    v = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  // table read: angle snapped to the table grid, quadrant folding onto the quarter wave
  function automatic void unit_circle_lookup(input logic [31:0] angle, output int cos_v,
                                             output int sin_v);
    logic [31:0] snapped;
    logic [63:0] frac;
    int rising;
    int falling;
    snapped = angle & ~((32'd1 << (32 - TABLE_BITS)) - 32'd1);
    frac    = {34'd0, snapped[29:0]};
    rising  = quarter_wave_q15(frac);
    falling = quarter_wave_q15((64'd1 << 30) - frac);
    case (snapped[31:30])
      QUAD_0: begin
        sin_v = rising;
        cos_v = falling;
      end
      QUAD_1: begin
        sin_v = falling;
        cos_v = -rising;
      end
      QUAD_2: begin
        sin_v = -rising;
        cos_v = -falling;
      end
      default: begin
        sin_v = -falling;
        cos_v = rising;
      end
    endcase
  endfunction

  function automatic longint clamp_power(input longint v);
    if (v > longint'(P_MAX)) return longint'(P_MAX);
    if (v < longint'(P_MIN)) return longint'(P_MIN);
    return v;
  endfunction

  // full series for one request under the given threshold
  function automatic series_outcome_t evaluate_series(input logic signed [15:0] z_re,
                                                      input logic signed [15:0] z_im,
                                                      input logic [15:0] ell,
                                                      input logic [31:0] phase,
                                                      input logic [TH_W-1:0] threshold);
    series_outcome_t outcome;
    logic [31:0] angle;
    longint pwr_re;
    longint pwr_im;
    longint next_re;
    longint next_im;
    longint total;
    longint mag;
    int cos_v;
    int sin_v;
    int n;
    bit done;
    angle          = phase * {15'd0, ell, 1'b1};
    pwr_re         = longint'(P_ONE);
    pwr_im         = 0;
    total          = 0;
    done           = 1'b0;
    outcome.capped = 1'b0;
    outcome.terms  = '0;
    for (n = 1; n <= TERM_CAP && !done; n++) begin
      unit_circle_lookup(angle, cos_v, sin_v);
      total = total + ((pwr_re * cos_v - pwr_im * sin_v + 32) >>> 6);
      if (total > longint'(ACC_MAX)) total = longint'(ACC_MAX);
      if (total < longint'(ACC_MIN)) total = longint'(ACC_MIN);
      next_re = clamp_power((pwr_re * z_re - pwr_im * z_im + 16384) >>> 15);
      next_im = clamp_power((pwr_re * z_im + pwr_im * z_re + 16384) >>> 15);
      pwr_re  = next_re;
      pwr_im  = next_im;
      angle   = angle << 1;
      mag     = pwr_re * pwr_re + pwr_im * pwr_im;
      outcome.terms = 7'(n);
      if (mag < longint'(threshold)) begin
        done = 1'b1;
      end else if (n == TERM_CAP) begin
        outcome.capped = 1'b1;
        done           = 1'b1;
      end
    end
    outcome.sum = total[31:0];
    return outcome;
  endfunction

  function automatic void note_mismatch(input string field, input longint want,
                                        input longint got);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endfunction

  // follow writes to the stop threshold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= TH_RESET;
    end else if (psel && penable && pwrite && pready && paddr == THRESHOLD_ADDR) begin
      threshold_q <= pwdata[TH_W-1:0];
    end
  end

  // predict each accepted request, compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : result_compare
    series_outcome_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_sums.push_back(evaluate_series(z_re_i, z_im_i, ell_i, phase_i, threshold_q));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, expected none, got sum %0d",
                   $time, series_sum_o);
        end else begin
          want = expected_sums.pop_front();
          if (series_sum_o !== want.sum) begin
            note_mismatch("series_sum", $signed(want.sum), series_sum_o);
          end
          if (terms_used_o !== want.terms) begin
            note_mismatch("terms_used", want.terms, terms_used_o);
          end
          if (not_converged_o !== want.capped) begin
            note_mismatch("not_converged", want.capped, not_converged_o);
          end
        end
      end
    end
    pending_o    <= expected_sums.size();
    fail_count_o <= mismatches;
  end

endmodule

>>> test/tb_lacunary_cosine_series.sv
// testbench top of the lacunary cosine series block: clock, reset, stimulus and verdict
module tb_lacunary_cosine_series;
  import lcs_pkg::*;

  localparam int unsigned TERM_CAP   = 64;
  localparam int unsigned TABLE_BITS = 10;
  localparam logic [ADDR_W-1:0] THRESHOLD_ADDR = {REG_STOP_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR  = {~REG_STOP_THRESHOLD, 2'b00};
  localparam int RESULT_LATENCY     = 5 * TERM_CAP + 4;
  localparam int HOLD_OFF_CYCLES    = 1500;
  localparam int CYCLE_LIMIT        = 3_000_000;
  localparam int RANDOM_PER_SETTING = 285;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [ADDR_W-1:0]  paddr           = '0;
  logic [DATA_W-1:0]  pwdata          = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] z_re_i          = '0;
  logic signed [15:0] z_im_i          = '0;
  logic [15:0]        ell_i           = '0;
  logic [31:0]        phase_i         = '0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic signed [31:0] series_sum_o;
  logic [6:0]         terms_used_o;
  logic               not_converged_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit hold_off_go = 1'b0;

  lacunary_cosine_series #(
    .MAX_TERMS     (TERM_CAP),
    .COS_TABLE_BITS(TABLE_BITS)
  ) DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .z_re_i, .z_im_i, .ell_i, .phase_i,
    .out_valid_o, .out_stall_i, .series_sum_o, .terms_used_o, .not_converged_o
  );

  lcs_series_checker #(
    .TERM_CAP  (TERM_CAP),
    .TABLE_BITS(TABLE_BITS)
  ) series_check (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .z_re_i, .z_im_i, .ell_i, .phase_i,
    .out_valid_o, .out_stall_i, .series_sum_o, .terms_used_o, .not_converged_o,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lacunary_cosine_series: FAILED **");
      $finish;
    end
  end

  // result side: random stall stretches, one long hold-off on demand
  initial begin : result_sink
    bit hold_off_done;
    int span;
    int style;
    int k;
    hold_off_done = 1'b0;
    forever begin
      if (hold_off_go && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        span  = $urandom_range(1, 40);
        style = $urandom_range(0, 3);
        for (k = 0; k < span; k++) begin
          case (style)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 99) < 30);
            2: out_stall_i <= ($urandom_range(0, 99) < 75);
            default: out_stall_i <= 1'b1;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // one request, held until taken
  task automatic issue_request(input logic signed [15:0] re, input logic signed [15:0] im,
                               input logic [15:0] ell, input logic [31:0] phase);
    in_valid_i <= 1'b1;
    z_re_i     <= re;
    z_im_i     <= im;
    ell_i      <= ell;
    phase_i    <= phase;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop sending until every predicted result has come back
  task automatic await_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // setup cycle then access cycle
  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly shrunk weights so the series converges, the rest full range
  function automatic logic signed [15:0] random_weight();
    logic signed [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(0, 9) < 6) begin
      w = w >>> $urandom_range(1, 3);
    end
    return w;
  endfunction

  function automatic logic [15:0] random_harmonic();
    if ($urandom_range(0, 1) == 1) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(0, 3));
  endfunction

  // random requests in bursts with gaps; with squeeze the first ones go back to back
  // while the result side holds off
  task automatic random_batch(input int count, input bit squeeze);
    int burst_left;
    int gap;
    int k;
    burst_left = 0;
    if (squeeze) begin
      hold_off_go <= 1'b1;
    end
    for (k = 0; k < count; k++) begin
      issue_request(random_weight(), random_weight(), random_harmonic(), $urandom);
      if (!(squeeze && k < 12)) begin
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          if (gap > 0) begin
            idle_sender(gap);
          end
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] threshold;
    int s;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold: zero weight, unit weight, growing weights, quadrant edges
    issue_request(16'sd0, 16'sd0, 16'd0, 32'h0000_0000);
    issue_request(16'sh8000, 16'sd0, 16'd0, 32'h0000_0000);
    issue_request(16'sh7fff, 16'sh7fff, 16'hffff, 32'hffff_ffff);
    issue_request(16'sh8000, 16'sh8000, 16'd0, 32'h0000_0000);
    issue_request(16'sd16384, -16'sd16384, 16'd1, 32'h4000_0000);
    issue_request(16'sd0, 16'sh7fff, 16'hffff, 32'h8000_0000);
    issue_request(16'sh8000, 16'sh7fff, 16'd12345, 32'hc000_0000);
    issue_request(16'sh7fff, 16'sd0, 16'd0, 32'h5555_5555);
    await_results();

    // zero threshold never stops early
    apb_write(THRESHOLD_ADDR, 32'd0);
    issue_request(16'sd0, 16'sd0, 16'd0, 32'h0000_0000);
    issue_request(16'sd16384, 16'sd0, 16'd0, 32'h0000_0000);
    issue_request(16'sh7fff, 16'sh8000, 16'hffff, 32'h0000_0000);
    await_results();

    // write to an unmapped register is ignored
    apb_write(UNMAPPED_ADDR, 32'hffff_ffff);
    issue_request(16'sd8192, 16'sd8192, 16'd7, 32'h1357_9bdf);
    await_results();

    // threshold crossed right on the last allowed term
    apb_write(THRESHOLD_ADDR, 32'd52_800_000);
    issue_request(16'sd32000, 16'sd0, 16'd3, 32'h1234_5678);
    issue_request(16'sd0, 16'sd32000, 16'd3, 32'h1234_5678);
    issue_request(-16'sd32000, 16'sd0, 16'd3, 32'h1234_5678);
    await_results();

    // largest threshold, upper data bits set
    apb_write(THRESHOLD_ADDR, 32'hffff_ffff);
    issue_request(16'sh7fff, 16'sd0, 16'd0, 32'h0000_0000);
    issue_request(16'sh8000, 16'sd0, 16'd0, 32'h0000_0000);
    issue_request(16'sd23170, 16'sd23170, 16'd100, 32'h0fed_cba9);
    await_results();

    // random requests under a range of thresholds
    for (s = 0; s < 6; s++) begin
      case (s)
        0: threshold = 32'd0;
        1: threshold = 32'd1;
        2: threshold = 32'h0010_0000;
        3: threshold = 32'h0400_0000;
        4: threshold = 32'h3fff_ffff;
        default: threshold = $urandom_range(0, 32'h3fff_ffff);
      endcase
      apb_write(THRESHOLD_ADDR, threshold);
      random_batch(RANDOM_PER_SETTING, s == 2);
      await_results();
    end

    repeat (RESULT_LATENCY + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** lacunary_cosine_series: PASSED **");
    end else begin
      $display("** lacunary_cosine_series: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/lcs_pkg.sv
sv/lcs_mac2.sv
sv/lacunary_cosine_series.sv
sv/lcs_checker.sv
test/lcs_series_checker.sv
test/tb_lacunary_cosine_series.sv
